@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared constants, codes and types for the block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BBA_MAX_BLOCKS = 512;
  localparam int BBA_MAX_RUN    = 10;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 9;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int FDB_W    = 9;
  localparam int TOTAL_W  = 10;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 10;

  localparam logic [CFG_IW-1:0] CFG_FIRST_DATA_BLOCK = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_TOTAL_BLOCKS     = 1'd1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  localparam int FDB_RESET   = 2;
  localparam int TOTAL_RESET = 512;

  typedef enum logic [MODE_W-1:0] {
    MODE_MARK  = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_ALLOC = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_OP,
    S_SCAN,
    S_SINGLE
  } state_t;

endpackage

@@ rtl/bba_if.sv @@
// ----------------------------------------------------------------------------
// Block allocator channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_req_if
  import bba_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [INDEX_W-1:0]   block_index;
  logic [COUNT_W-1:0]   block_count;

  modport source (output valid, mode, block_index, block_count, input ready);
  modport sink (input valid, mode, block_index, block_count, output ready);
endinterface

interface bba_res_if
  import bba_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [INDEX_W-1:0]   result_block;
  logic                 used_bit;
  logic [STATUS_W-1:0]  status;
  logic                 last;

  modport source (output valid, result_block, used_bit, status, last, input ready);
  modport sink (input valid, result_block, used_bit, status, last, output ready);
endinterface

@@ rtl/bitmap_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Used map of disk blocks with mark, free, test and first-fit allocation.
//
//   Channel   Direction  Beat contents
//   req       in         mode, block_index, block_count
//   res       out        result_block, used_bit, status, last
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// Mark, free and test pass through accept, map read and update.
// Allocation reads the map a word at a time from the first data block and
// claims the free blocks it finds in each word before moving to the next.
// After reset a clearing pass writes every map word before the first
// request is taken. A stalled result beat holds the scan.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = BBA_MAX_BLOCKS,
  parameter int MAX_RUN    = BBA_MAX_RUN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  bba_req_if.sink           req,
  bba_res_if.source         res
);

  localparam int WORDS  = (MAX_BLOCKS + 7) / 8;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LB     = $clog2(MAX_BLOCKS + 1);
  localparam int LW     = (LB > TOTAL_W) ? LB : TOTAL_W;
  localparam int XW     = (LW > AW + 4) ? LW : AW + 4;
  localparam int CW     = $clog2(MAX_RUN + 1);

  logic [7:0]          mem [WORDS];
  logic [7:0]          rdata;
  logic                mem_we;
  logic                mem_re;
  logic [7:0]          mem_wdata;
  logic [AW-1:0]       mem_addr;

  state_t              state;
  state_t              state_next;
  logic [FDB_W-1:0]    fdb;
  logic [TOTAL_W-1:0]  tblk;
  logic [AW-1:0]       clr;
  logic [AW-1:0]       waddr;
  logic [2:0]          bofs;
  mode_t               mode_r;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       k;
  logic [7:0]          word;
  logic                fresh;
  logic [INDEX_W-1:0]  sblk;
  logic [STATUS_W-1:0] sst;

  logic                ov;
  logic [INDEX_W-1:0]  r_blk;
  logic                r_used;
  logic [STATUS_W-1:0] r_st;
  logic                r_last;

  logic [LW-1:0]       lim;
  logic [XW-1:0]       lim_x;
  logic [XW-1:0]       fdb_x;
  logic [XW-1:0]       idx_x;
  logic [XW-1:0]       base_x;
  logic [XW-1:0]       next_x;
  logic                acc;
  logic                bad_idx;
  logic                zero_cnt;
  logic                empty_rng;
  logic [CW-1:0]       cnt_sat;
  logic                slot_free;
  logic [7:0]          cur;
  logic [7:0]          elig;
  logic                found;
  logic [2:0]          pick;
  logic [7:0]          op_mask;
  logic [7:0]          new_word;
  logic                is_last;
  logic                out_load;
  logic [INDEX_W-1:0]  out_blk;
  logic                out_used;
  logic [STATUS_W-1:0] out_st;
  logic                out_last;

  assign lim    = (LW'(tblk) < LW'(MAX_BLOCKS)) ? LW'(tblk) : LW'(MAX_BLOCKS);
  assign lim_x  = XW'(lim);
  assign fdb_x  = XW'(fdb);
  assign idx_x  = XW'(req.block_index);
  assign base_x = XW'({waddr, 3'b000});
  assign next_x = base_x + XW'(8);

  assign acc       = req.valid && req.ready;
  assign bad_idx   = (idx_x >= lim_x);
  assign zero_cnt  = (req.block_count == '0);
  assign empty_rng = (fdb_x >= lim_x);
  assign cnt_sat   = (32'(req.block_count) > MAX_RUN) ? CW'(MAX_RUN) : CW'(req.block_count);
  assign slot_free = !ov || res.ready;

  assign cur      = fresh ? rdata : word;
  assign op_mask  = 8'h80 >> bofs;
  assign is_last  = ((k + CW'(1)) == cnt);

  always_comb begin
    elig = '0;
    for (int j = 0; j < 8; j++) begin
      elig[j] = !cur[7-j] && ((base_x + XW'(j)) >= fdb_x) && ((base_x + XW'(j)) < lim_x);
    end
  end

  always_comb begin
    pick = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (elig[j]) begin
        pick = 3'(j);
      end
    end
  end

  assign found    = |elig;
  assign new_word = found ? (cur | (8'h80 >> pick)) : cur;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == AW'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (mode_t'(req.mode) != MODE_ALLOC) begin
            state_next = bad_idx ? S_SINGLE : S_READ;
          end else begin
            state_next = (zero_cnt || empty_rng) ? S_SINGLE : S_READ;
          end
        end
      end
      S_READ: begin
        state_next = (mode_r == MODE_ALLOC) ? S_SCAN : S_OP;
      end
      S_OP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (found) begin
          if (slot_free && is_last) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = (next_x >= lim_x) ? S_SINGLE : S_READ;
        end
      end
      S_SINGLE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = 8'h00;
    mem_addr  = waddr;
    out_load  = 1'b0;
    out_blk   = '0;
    out_used  = 1'b0;
    out_st    = ST_OK;
    out_last  = 1'b1;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr;
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_OP: begin
        case (mode_r)
          MODE_MARK: mem_wdata = rdata | op_mask;
          MODE_FREE: mem_wdata = rdata & ~op_mask;
          default:   mem_wdata = rdata;
        endcase
        mem_we   = slot_free;
        out_load = slot_free;
        out_blk  = INDEX_W'({waddr, bofs});
        out_used = |(mem_wdata & op_mask);
      end
      S_SCAN: begin
        mem_wdata = new_word;
        mem_we    = !found || (slot_free && is_last);
        out_load  = found && slot_free;
        out_blk   = INDEX_W'(base_x + XW'(pick));
        out_used  = 1'b1;
        out_last  = is_last;
      end
      S_SINGLE: begin
        out_load = slot_free;
        out_blk  = sblk;
        out_st   = sst;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      fdb   <= FDB_W'(FDB_RESET);
      tblk  <= TOTAL_W'(TOTAL_RESET);
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_DATA_BLOCK: fdb <= cfg_data[FDB_W-1:0];
          CFG_TOTAL_BLOCKS:     tblk <= cfg_data[TOTAL_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      r_blk  <= out_blk;
      r_used <= out_used;
      r_st   <= out_st;
      r_last <= out_last;
    end
    case (state)
      S_IDLE: begin
        if (acc) begin
          mode_r <= mode_t'(req.mode);
          cnt    <= cnt_sat;
          k      <= '0;
          bofs   <= req.block_index[2:0];
          if (mode_t'(req.mode) != MODE_ALLOC) begin
            sblk  <= req.block_index;
            sst   <= ST_BAD;
            waddr <= idx_x[AW+2:3];
          end else begin
            sblk  <= '0;
            sst   <= zero_cnt ? ST_BAD : ST_NOSPACE;
            waddr <= fdb_x[AW+2:3];
          end
        end
      end
      S_READ: begin
        fresh <= 1'b1;
      end
      S_SCAN: begin
        if (found) begin
          fresh <= 1'b0;
          if (slot_free) begin
            word <= new_word;
            k    <= k + CW'(1);
          end else begin
            word <= cur;
          end
        end else begin
          waddr <= waddr + AW'(1);
          sblk  <= '0;
          sst   <= ST_NOSPACE;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready        = (state == S_IDLE);
  assign res.valid        = ov;
  assign res.result_block = r_blk;
  assign res.used_bit     = r_used;
  assign res.status       = r_st;
  assign res.last         = r_last;

endmodule

@@ rtl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// Block allocator port checker
// Checks on the result channel of the block allocator, bound to the allocator unit.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [INDEX_W-1:0]  res_block,
  input logic                res_used,
  input logic [STATUS_W-1:0] res_status,
  input logic                res_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result beat present right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_block) && $stable(res_status))
    else $error("Stalled result beat changed.");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_BAD || res_status == ST_NOSPACE) |-> res_last && !res_used)
    else $error("Error beat is not a final beat with a clear bit.");

  a_nospace_block: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_NOSPACE |-> res_block == '0)
    else $error("No-space beat carries a block number.");

  a_run_used: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_OK && !res_last |-> res_used)
    else $error("Allocated block reported as free.");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_block  (res.result_block),
  .res_used   (res.used_bit),
  .res_status (res.status),
  .res_last   (res.last)
);

@@ dv/bitmap_block_allocator_unit_test.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives mark, free, test and allocate requests through several register
// settings and checks every result beat against a bit-level model of the
// used map, with random idling on both channels.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit_test
  import bba_pkg::*;
();

  localparam int HALF_PERIOD = 4;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 20;
  localparam int TIMEOUT     = 4000000;

  class block_map_scoreboard;
    typedef struct packed {
      logic [INDEX_W-1:0]  block;
      logic                used;
      logic [STATUS_W-1:0] status;
      logic                last;
    } alloc_beat_t;

    bit                 used_map[BBA_MAX_BLOCKS];
    logic [FDB_W-1:0]   first_data_block;
    logic [TOTAL_W-1:0] total_blocks;
    alloc_beat_t        awaited[$];
    int unsigned        errors;
    int unsigned        n_requests;
    int unsigned        n_beats;
    int unsigned        n_nospace;
    int unsigned        n_rejected;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      first_data_block = FDB_W'(FDB_RESET);
      total_blocks     = TOTAL_W'(TOTAL_RESET);
    endfunction

    function int unsigned block_limit();
      return (total_blocks < BBA_MAX_BLOCKS) ? total_blocks : BBA_MAX_BLOCKS;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void set_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == CFG_FIRST_DATA_BLOCK) begin
        first_data_block = data[FDB_W-1:0];
      end else if (idx == CFG_TOTAL_BLOCKS) begin
        total_blocks = data[TOTAL_W-1:0];
      end
    endfunction

    function void push(int unsigned blk, bit used, logic [STATUS_W-1:0] st, bit last);
      alloc_beat_t r;
      r.block  = INDEX_W'(blk);
      r.used   = used;
      r.status = st;
      r.last   = last;
      awaited.push_back(r);
      if (st == ST_NOSPACE) n_nospace++;
      if (st == ST_BAD) n_rejected++;
    endfunction

    function void note_request(mode_t m, logic [INDEX_W-1:0] idx, logic [COUNT_W-1:0] cnt);
      int unsigned lim;
      int unsigned want;
      int unsigned found;
      int unsigned b;
      n_requests++;
      lim = block_limit();
      if (m != MODE_ALLOC) begin
        if (idx >= lim) begin
          push(idx, 1'b0, ST_BAD, 1'b1);
        end else begin
          if (m == MODE_MARK) used_map[idx] = 1'b1;
          else if (m == MODE_FREE) used_map[idx] = 1'b0;
          push(idx, used_map[idx], ST_OK, 1'b1);
        end
        return;
      end
      if (cnt == 0) begin
        push(0, 1'b0, ST_BAD, 1'b1);
        return;
      end
      want  = (cnt > BBA_MAX_RUN) ? BBA_MAX_RUN : cnt;
      found = 0;
      for (b = first_data_block; b < lim && found < want; b++) begin
        if (!used_map[b]) begin
          used_map[b] = 1'b1;
          found++;
          push(b, 1'b1, ST_OK, found == want);
        end
      end
      if (found < want) push(0, 1'b0, ST_NOSPACE, 1'b1);
    endfunction

    function void check_result(logic [INDEX_W-1:0] blk, logic used, logic [STATUS_W-1:0] st,
                               logic last);
      alloc_beat_t e;
      n_beats++;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: block %0d status %0d", blk, st);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (blk !== e.block) begin
        $error("result_block: expected %0d, actual %0d", e.block, blk);
        errors++;
      end
      if (used !== e.used) begin
        $error("used_bit: expected %0d, actual %0d", e.used, used);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  bit                calm = 1'b0;
  int unsigned       n_settings = 1;

  block_map_scoreboard sb;

  bba_req_if req();
  bba_res_if res();

  bitmap_block_allocator_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req.sink),
    .res      (res.source)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      sb.check_result(res.result_block, res.used_bit, res.status, res.last);
    end
  end

  task automatic send_request(mode_t m, logic [INDEX_W-1:0] idx, logic [COUNT_W-1:0] cnt);
    req.valid       <= 1'b1;
    req.mode        <= m;
    req.block_index <= idx;
    req.block_count <= cnt;
    do @(posedge clk); while (!req.ready);
    sb.note_request(m, idx, cnt);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_DW-1:0] fdb_val, logic [CFG_DW-1:0] total_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_DATA_BLOCK;
    cfg_data  <= fdb_val;
    @(posedge clk);
    sb.set_register(CFG_FIRST_DATA_BLOCK, fdb_val);
    cfg_index <= CFG_TOTAL_BLOCKS;
    cfg_data  <= total_val;
    @(posedge clk);
    sb.set_register(CFG_TOTAL_BLOCKS, total_val);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_request();
    int unsigned        lim;
    int unsigned        pick;
    mode_t              m;
    logic [INDEX_W-1:0] idx;
    logic [COUNT_W-1:0] cnt;
    lim  = sb.block_limit();
    pick = $urandom_range(0, 99);
    idx  = INDEX_W'($urandom);
    cnt  = COUNT_W'($urandom);
    if (pick < 40) begin
      m = MODE_ALLOC;
      if ($urandom_range(0, 6) != 0) cnt = COUNT_W'($urandom_range(1, BBA_MAX_RUN));
    end else begin
      if (pick < 64) m = MODE_FREE;
      else if (pick < 82) m = MODE_MARK;
      else m = MODE_TEST;
      if (lim > 0 && $urandom_range(0, 4) != 0) idx = INDEX_W'($urandom_range(0, lim - 1));
    end
    send_request(m, idx, cnt);
  endtask

  task automatic run_phase(logic [CFG_DW-1:0] fdb_val, logic [CFG_DW-1:0] total_val, int n);
    wait_idle();
    write_config(fdb_val, total_val);
    repeat (n) random_request();
  endtask

  initial begin
    sb = new();
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    req.valid       = 1'b0;
    req.mode        = MODE_MARK;
    req.block_index = '0;
    req.block_count = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(MODE_TEST, 9'd0, 4'd0);
    send_request(MODE_MARK, 9'd0, 4'd15);
    send_request(MODE_TEST, 9'd0, 4'd0);
    send_request(MODE_FREE, 9'd0, 4'd0);
    send_request(MODE_TEST, 9'd0, 4'd0);
    send_request(MODE_MARK, 9'd511, 4'd0);
    send_request(MODE_TEST, 9'd511, 4'd0);
    send_request(MODE_FREE, 9'd511, 4'd0);
    send_request(MODE_ALLOC, 9'd0, 4'd0);
    send_request(MODE_ALLOC, 9'd511, 4'd1);
    send_request(MODE_ALLOC, 9'd0, 4'd10);
    send_request(MODE_ALLOC, 9'd0, 4'd15);

    wait_idle();
    write_config(10'd5, 10'd20);
    send_request(MODE_TEST, 9'd20, 4'd0);
    send_request(MODE_MARK, 9'd511, 4'd0);
    send_request(MODE_ALLOC, 9'd0, 4'd15);
    send_request(MODE_FREE, 9'd7, 4'd0);
    send_request(MODE_FREE, 9'd9, 4'd0);
    send_request(MODE_ALLOC, 9'd0, 4'd5);

    wait_idle();
    write_config(10'd30, 10'd20);
    send_request(MODE_ALLOC, 9'd0, 4'd1);

    wait_idle();
    write_config(10'd0, 10'd0);
    send_request(MODE_TEST, 9'd0, 4'd0);
    send_request(MODE_ALLOC, 9'd0, 4'd3);

    run_phase(10'd2, 10'd512, 50);
    run_phase(10'd0, 10'd1023, 40);
    run_phase(10'h3FF, 10'd512, 25);
    run_phase(10'd0, 10'd1, 25);
    run_phase(10'd3, 10'd64, 60);
    run_phase(CFG_DW'($urandom_range(0, 40)), CFG_DW'($urandom_range(16, 200)), 60);
    run_phase(10'd0, 10'd0, 15);
    wait_idle();
    calm = 1'b1;
    run_phase(10'd0, 10'd512, 75);

    wait_idle();
    repeat (TAIL) @(posedge clk);
    $display("Covered %0d requests and %0d result beats over %0d register settings.",
             sb.n_requests, sb.n_beats, n_settings);
    $display("Scans that ran out of space: %0d, rejected requests: %0d.",
             sb.n_nospace, sb.n_rejected);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bitmap_block_allocator_unit: match");
    end else begin
      $display("bitmap_block_allocator_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("Timed out with %0d result beats still awaited.", sb.pending());
    $display("bitmap_block_allocator_unit: mismatch");
    $finish;
  end

endmodule
